// ----- rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, codes and the key compare for the segment reference table.
// ----------------------------------------------------------------------------
package srt_pkg;

   // width of the reported entry index
   localparam int unsigned IDX_OUT_W = 4;

   // request operation codes
   typedef enum logic [1:0] {
      OP_LOOKUP  = 2'd0,
      OP_INSERT  = 2'd1,
      OP_RELEASE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      RC_OK       = 2'd0,
      RC_NO_MATCH = 2'd1,
      RC_FULL     = 2'd2
   } rsp_code_type;

   // source of the reported entry index
   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_CMP  = 2'd1,
      SRC_SCAN = 2'd2
   } idx_src_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_LOOKUP = 2'd1,
      S_INSERT = 2'd2,
      S_DONE   = 2'd3
   } ctrl_state_type;

   // one reassembly key
   typedef struct packed {
      logic [23:0] origin_pc;
      logic [23:0] dest_pc;
      logic [7:0]  link_sel;
      logic [23:0] local_ref;
      logic        calling_pc_flag;
      logic        calling_ssn_flag;
      logic [3:0]  title_kind;
      logic [23:0] calling_pc;
      logic [7:0]  calling_ssn;
   } key_type;

   // controller to datapath commands
   typedef struct packed {
      logic         load;      // capture request key, restart the scan
      logic         issue;     // read one key entry for comparison
      logic         step;      // advance the free-entry scan
      logic         take;      // write key into scanned entry, mark busy
      logic         free_one;  // free the selected entry
      logic         clear;     // free all entries
      logic         set_res;   // latch the pending result
      rsp_code_type res_code;
      idx_src_type  res_src;
      logic         push;      // move pending result to the output register
   } srt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic hit;         // compared entry is busy and matches
      logic cmp_last;    // compared entry was the last one
      logic issue_done;  // all entries have been read
      logic scan_free;   // scanned entry is free
      logic scan_last;   // scanned entry is the last one
      logic rsp_free;    // output register can take a result
   } srt_stat_type;

   // calling point code and subsystem only count when flagged
   function automatic logic key_match(key_type stored, key_type probe);
      logic base_eq;
      logic pc_eq;
      logic ssn_eq;
      base_eq = (stored.origin_pc == probe.origin_pc)
             && (stored.dest_pc == probe.dest_pc)
             && (stored.link_sel == probe.link_sel)
             && (stored.local_ref == probe.local_ref)
             && (stored.calling_pc_flag == probe.calling_pc_flag)
             && (stored.calling_ssn_flag == probe.calling_ssn_flag)
             && (stored.title_kind == probe.title_kind);
      pc_eq  = !probe.calling_pc_flag || (stored.calling_pc == probe.calling_pc);
      ssn_eq = !probe.calling_ssn_flag || (stored.calling_ssn == probe.calling_ssn);
      return base_eq && pc_eq && ssn_eq;
   endfunction

endpackage

// ----- rtl/srt_req_if.sv -----
// ----------------------------------------------------------------------------
// srt_req_if
// Request channel: valid/ready handshake with the table operation and key.
// ----------------------------------------------------------------------------
interface srt_req_if import srt_pkg::*; ();

   logic        valid;
   logic        ready;
   op_type      opcode;
   logic [23:0] origin_pc;
   logic [23:0] dest_pc;
   logic [7:0]  link_sel;
   logic [23:0] local_ref;
   logic        calling_pc_flag;
   logic        calling_ssn_flag;
   logic [3:0]  title_kind;
   logic [23:0] calling_pc;
   logic [7:0]  calling_ssn;
   logic [3:0]  entry_sel;

   modport source (
      output valid, opcode, origin_pc, dest_pc, link_sel, local_ref,
             calling_pc_flag, calling_ssn_flag, title_kind, calling_pc,
             calling_ssn, entry_sel,
      input  ready
   );

   modport sink (
      input  valid, opcode, origin_pc, dest_pc, link_sel, local_ref,
             calling_pc_flag, calling_ssn_flag, title_kind, calling_pc,
             calling_ssn, entry_sel,
      output ready
   );

endinterface

// ----- rtl/srt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// srt_rsp_if
// Response channel: valid/ready handshake with status and entry index.
// ----------------------------------------------------------------------------
interface srt_rsp_if import srt_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [IDX_OUT_W-1:0] entry_index;

   modport source (
      output valid, status, entry_index,
      input  ready
   );

   modport sink (
      input  valid, status, entry_index,
      output ready
   );

endinterface

// ----- rtl/srt_ctrl.sv -----
// ----------------------------------------------------------------------------
// srt_ctrl
// Controller: sequences lookup scan, insert scan, release, clear and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module srt_ctrl import srt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  op_type       req_opcode,
   output logic         req_ready,
   input  srt_stat_type stat,
   output srt_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  OP_LOOKUP:  state_in = S_LOOKUP;
                  OP_INSERT:  state_in = S_INSERT;
                  OP_RELEASE: state_in = S_DONE;
                  OP_CLEAR:   state_in = S_DONE;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_LOOKUP: begin
            if (stat.hit || stat.cmp_last) begin
               state_in = S_DONE;
            end
         end
         S_INSERT: begin
            if (stat.scan_free || stat.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      cmd.res_code = RC_OK;
      cmd.res_src  = SRC_ZERO;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_opcode == OP_RELEASE) begin
                  cmd.free_one = 1'b1;
                  cmd.set_res  = 1'b1;
               end else if (req_opcode == OP_CLEAR) begin
                  cmd.clear   = 1'b1;
                  cmd.set_res = 1'b1;
               end
            end
         end
         S_LOOKUP: begin
            if (stat.hit) begin
               cmd.set_res = 1'b1;
               cmd.res_src = SRC_CMP;
            end else if (stat.cmp_last) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RC_NO_MATCH;
            end else if (!stat.issue_done) begin
               cmd.issue = 1'b1;
            end
         end
         S_INSERT: begin
            if (stat.scan_free) begin
               cmd.take    = 1'b1;
               cmd.set_res = 1'b1;
               cmd.res_src = SRC_SCAN;
            end else if (stat.scan_last) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RC_FULL;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DONE: begin
            cmd.push = stat.rsp_free;
         end
         default: begin
            cmd.push = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/srt_datapath.sv -----
// ----------------------------------------------------------------------------
// srt_datapath
// Datapath: key memory, busy marks, scan counter, registered key compare,
// pending result and output register.
// ----------------------------------------------------------------------------
module srt_datapath import srt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  key_type              req_key,
   input  logic [3:0]           req_entry_sel,
   input  srt_cmd_type          cmd,
   output srt_stat_type         stat,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rsp_code_type         rsp_code,
   output logic [IDX_OUT_W-1:0] rsp_index
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   // key storage, written only by insert
   key_type key_mem [ENTRIES];

   logic [ENTRIES-1:0]   busy_ff, busy_in;
   key_type              key_ff;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]        cmp_idx_ff;
   logic                 cmp_busy_ff;
   key_type              rd_key_ff;
   rsp_code_type         res_code_ff;
   logic [IDX_OUT_W-1:0] res_idx_ff, res_idx_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_code_type         rsp_code_ff;
   logic [IDX_OUT_W-1:0] rsp_idx_ff;

   // busy marks: set on take, cleared by release or clear
   always_comb begin
      busy_in = busy_ff;
      for (int e = 0; e < ENTRIES; e++) begin
         if (cmd.clear) begin
            busy_in[e] = 1'b0;
         end else if (cmd.free_one && (e == int'(req_entry_sel))) begin
            busy_in[e] = 1'b0;
         end else if (cmd.take && (e == int'(idx_ff))) begin
            busy_in[e] = 1'b1;
         end
      end
   end

   // scan counter, shared by lookup reads and the free-entry search
   always_comb begin
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      if (cmd.load) begin
         idx_in        = '0;
         issue_done_in = 1'b0;
      end else if (cmd.issue || cmd.step) begin
         if (idx_ff == LAST) begin
            issue_done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   assign cmp_vld_in = cmd.issue;

   // reported index of the pending result
   always_comb begin
      unique case (cmd.res_src)
         SRC_ZERO: res_idx_in = '0;
         SRC_CMP:  res_idx_in = IDX_OUT_W'(cmp_idx_ff);
         SRC_SCAN: res_idx_in = IDX_OUT_W'(idx_ff);
         default:  res_idx_in = '0;
      endcase
   end

   // output register: loads on push, empties when taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (cmd.push) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      issue_done_ff <= issue_done_in;
      if (cmd.load) begin
         key_ff <= req_key;
      end
      if (cmd.issue) begin
         cmp_idx_ff  <= idx_ff;
         cmp_busy_ff <= busy_ff[idx_ff];
      end
      if (cmd.set_res) begin
         res_code_ff <= cmd.res_code;
         res_idx_ff  <= res_idx_in;
      end
      if (cmd.push) begin
         rsp_code_ff <= res_code_ff;
         rsp_idx_ff  <= res_idx_ff;
      end
   end

   // key memory write port
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         key_mem[idx_ff] <= key_ff;
      end
   end

   // key memory read port, registered
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_key_ff <= key_mem[idx_ff];
      end
   end

   // status back to the controller
   always_comb begin
      stat.hit        = cmp_vld_ff && cmp_busy_ff && key_match(rd_key_ff, key_ff);
      stat.cmp_last   = cmp_vld_ff && (cmp_idx_ff == LAST);
      stat.issue_done = issue_done_ff;
      stat.scan_free  = !busy_ff[idx_ff];
      stat.scan_last  = (idx_ff == LAST);
      stat.rsp_free   = !rsp_vld_ff || rsp_ready;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_code  = rsp_code_ff;
   assign rsp_index = rsp_idx_ff;

endmodule

// ----- rtl/segment_reference_table.sv -----
// ----------------------------------------------------------------------------
// segment_reference_table
// Reassembly reference table: lookup, insert, release and clear of keyed
// entries with busy marks.
// ----------------------------------------------------------------------------
// One request is handled at a time. A lookup reads the key memory one entry
// per cycle through its single registered read port and stops at the first
// busy match. An insert scans the busy marks one entry per cycle for the
// first free entry. Release and clear update the busy marks with no scan.
// The result sits in an output register; the next request is accepted once
// the previous result has been loaded there. The table is empty after reset
// with no clearing pass; the entry index reports the low four bits.
// ----------------------------------------------------------------------------
module segment_reference_table import srt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   srt_req_if.sink     req_chan,
   srt_rsp_if.source   rsp_chan
);

   srt_cmd_type          cmd;
   srt_stat_type         stat;
   key_type              req_key;
   rsp_code_type         rsp_code;
   logic                 rsp_valid;
   logic [IDX_OUT_W-1:0] rsp_index;
   logic                 req_ready;

   // gather the request key
   always_comb begin
      req_key.origin_pc        = req_chan.origin_pc;
      req_key.dest_pc          = req_chan.dest_pc;
      req_key.link_sel         = req_chan.link_sel;
      req_key.local_ref        = req_chan.local_ref;
      req_key.calling_pc_flag  = req_chan.calling_pc_flag;
      req_key.calling_ssn_flag = req_chan.calling_ssn_flag;
      req_key.title_kind       = req_chan.title_kind;
      req_key.calling_pc       = req_chan.calling_pc;
      req_key.calling_ssn      = req_chan.calling_ssn;
   end

   srt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_key       (req_key),
      .req_entry_sel (req_chan.entry_sel),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_valid),
      .rsp_code      (rsp_code),
      .rsp_index     (rsp_index)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.status      = rsp_code;
   assign rsp_chan.entry_index = rsp_index;

endmodule

// ----- dv/segment_reference_table_test.sv -----
// ----------------------------------------------------------------------------
// segment_reference_table_test
// Self-checking bench for the reassembly reference table. A directed table
// (fill, full, flag masking, duplicate keys, release, clear) is followed by
// random request traffic built mostly from keys already inserted.
// Directed results are pinned by hand; random ones come from a bench predictor.
// ----------------------------------------------------------------------------
module segment_reference_table_test import srt_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 1825;
   localparam int LATENCY_SLACK = 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;

   // one table result
   typedef struct packed {
      rsp_code_type status;
      logic [3:0]   index;
   } table_result_type;

   // result fixed by hand for a directed transaction
   typedef struct packed {
      logic         pinned;
      rsp_code_type status;
      logic [3:0]   index;
   } pinned_result_type;

   // one directed row: operation, key pattern, release index, pinned result
   typedef struct packed {
      op_type       op;
      logic [7:0]   pattern;
      logic [3:0]   sel;
      logic         pinned;
      rsp_code_type status;
      logic [3:0]   index;
   } stim_row_type;

   // key patterns: 0 all zero, 1 all ones, 2 flags clear, 3 same as 2 with
   // other calling address (still a hit), 4 same as 2 with pc flag set
   localparam stim_row_type DIRECTED [25] = '{
      '{OP_RELEASE, 8'd0,  4'd5,  1'b1, RC_OK,       4'd0},   // free entry
      '{OP_INSERT,  8'd0,  4'd0,  1'b1, RC_OK,       4'd0},
      '{OP_INSERT,  8'd1,  4'd0,  1'b1, RC_OK,       4'd1},
      '{OP_INSERT,  8'd2,  4'd0,  1'b1, RC_OK,       4'd2},
      '{OP_INSERT,  8'd5,  4'd0,  1'b1, RC_OK,       4'd3},
      '{OP_INSERT,  8'd6,  4'd0,  1'b1, RC_OK,       4'd4},
      '{OP_INSERT,  8'd7,  4'd0,  1'b1, RC_OK,       4'd5},
      '{OP_INSERT,  8'd8,  4'd0,  1'b1, RC_OK,       4'd6},
      '{OP_INSERT,  8'd9,  4'd0,  1'b1, RC_OK,       4'd7},
      '{OP_INSERT,  8'd10, 4'd0,  1'b1, RC_OK,       4'd8},
      '{OP_INSERT,  8'd11, 4'd0,  1'b1, RC_OK,       4'd9},
      '{OP_INSERT,  8'd12, 4'd0,  1'b1, RC_OK,       4'd10},
      '{OP_INSERT,  8'd13, 4'd0,  1'b1, RC_OK,       4'd11},
      '{OP_INSERT,  8'd14, 4'd0,  1'b1, RC_OK,       4'd12},
      '{OP_INSERT,  8'd15, 4'd0,  1'b1, RC_OK,       4'd13},
      '{OP_INSERT,  8'd16, 4'd0,  1'b1, RC_OK,       4'd14},
      '{OP_INSERT,  8'd17, 4'd0,  1'b1, RC_OK,       4'd15},
      '{OP_INSERT,  8'd6,  4'd0,  1'b1, RC_FULL,     4'd0},   // table full
      '{OP_LOOKUP,  8'd3,  4'd0,  1'b1, RC_OK,       4'd2},   // masked fields
      '{OP_LOOKUP,  8'd4,  4'd0,  1'b1, RC_NO_MATCH, 4'd0},   // flag differs
      '{OP_RELEASE, 8'd0,  4'd15, 1'b1, RC_OK,       4'd0},
      '{OP_INSERT,  8'd1,  4'd0,  1'b1, RC_OK,       4'd15},  // duplicate key
      '{OP_LOOKUP,  8'd1,  4'd0,  1'b1, RC_OK,       4'd1},   // lowest wins
      '{OP_CLEAR,   8'd0,  4'd0,  1'b1, RC_OK,       4'd0},
      '{OP_LOOKUP,  8'd0,  4'd0,  1'b1, RC_NO_MATCH, 4'd0}    // empty table
   };

   logic clock = 1'b0;
   logic reset;
   logic rsp_ready_q = 1'b0;

   srt_req_if req_chan ();
   srt_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_ready_q;

   segment_reference_table #(
      .ENTRIES (TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench copy of the table
   bit      entry_busy [TABLE_DEPTH];
   key_type entry_key  [TABLE_DEPTH];

   table_result_type  expected_q [$];
   pinned_result_type pinned_q [$];
   key_type           key_pool [$];

   int send_idle_pct  = 10;
   int recv_stall_pct = 61;
   int fail_count     = 0;
   int cycle_count    = 0;

   // busy entry matches when all key fields agree, calling pc and ssn
   // only where the probe flags them
   function automatic bit entry_hit(int e, key_type probe);
      key_type s;
      s = entry_key[e];
      if ({s.origin_pc, s.dest_pc, s.link_sel, s.local_ref} !=
          {probe.origin_pc, probe.dest_pc, probe.link_sel, probe.local_ref})
         return 1'b0;
      if ({s.calling_pc_flag, s.calling_ssn_flag, s.title_kind} !=
          {probe.calling_pc_flag, probe.calling_ssn_flag, probe.title_kind})
         return 1'b0;
      if (probe.calling_pc_flag && s.calling_pc != probe.calling_pc)
         return 1'b0;
      if (probe.calling_ssn_flag && s.calling_ssn != probe.calling_ssn)
         return 1'b0;
      return 1'b1;
   endfunction

   // apply one request to the bench table, return the response it gives
   function automatic table_result_type table_apply(op_type op, key_type probe,
                                                    logic [3:0] sel);
      table_result_type r;
      r.status = RC_OK;
      r.index  = '0;
      case (op)
         OP_LOOKUP: begin
            r.status = RC_NO_MATCH;
            for (int e = 0; e < TABLE_DEPTH; e++) begin
               if (entry_busy[e] && entry_hit(e, probe)) begin
                  r.status = RC_OK;
                  r.index  = 4'(e);
                  break;
               end
            end
         end
         OP_INSERT: begin
            r.status = RC_FULL;
            for (int e = 0; e < TABLE_DEPTH; e++) begin
               if (!entry_busy[e]) begin
                  entry_busy[e] = 1'b1;
                  entry_key[e]  = probe;
                  r.status      = RC_OK;
                  r.index       = 4'(e);
                  break;
               end
            end
         end
         OP_RELEASE: begin
            if (int'(sel) < TABLE_DEPTH)
               entry_busy[sel] = 1'b0;
         end
         default: begin
            entry_busy = '{default: 1'b0};
         end
      endcase
      return r;
   endfunction

   // directed key patterns
   function automatic key_type key_pattern(int n);
      key_type k;
      k = '0;
      case (n)
         0: k = '0;
         1: k = '1;
         2, 3, 4: begin
            k.origin_pc   = 24'h00A1B2;
            k.dest_pc     = 24'h00C3D4;
            k.link_sel    = 8'h17;
            k.local_ref   = 24'h000042;
            k.title_kind  = 4'h5;
            k.calling_pc  = (n == 3) ? 24'hABCDEF : 24'h123456;
            k.calling_ssn = (n == 3) ? 8'h01 : 8'h9A;
            k.calling_pc_flag = (n == 4);
         end
         default: begin
            k.origin_pc        = 24'(n * 32'h0001_0203);
            k.dest_pc          = 24'(n * 32'h0030_2011);
            k.link_sel         = 8'(n);
            k.local_ref        = 24'(n << 4);
            k.calling_pc_flag  = n[0];
            k.calling_ssn_flag = n[1];
            k.title_kind       = 4'(n);
            k.calling_pc       = 24'(n * 32'h1111);
            k.calling_ssn      = 8'(~n);
         end
      endcase
      return k;
   endfunction

   task automatic log_mismatch(string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // put a request payload on the channel
   task automatic drive_request(op_type op, key_type k, logic [3:0] sel);
      req_chan.opcode           <= op;
      req_chan.origin_pc        <= k.origin_pc;
      req_chan.dest_pc          <= k.dest_pc;
      req_chan.link_sel         <= k.link_sel;
      req_chan.local_ref        <= k.local_ref;
      req_chan.calling_pc_flag  <= k.calling_pc_flag;
      req_chan.calling_ssn_flag <= k.calling_ssn_flag;
      req_chan.title_kind       <= k.title_kind;
      req_chan.calling_pc       <= k.calling_pc;
      req_chan.calling_ssn      <= k.calling_ssn;
      req_chan.entry_sel        <= sel;
   endtask

   // one request transaction, with random idle cycles ahead of it
   task automatic send_request(op_type op, key_type k, logic [3:0] sel,
                               pinned_result_type pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      pinned_q.push_back(pin);
      drive_request(op, k, sel);
      req_chan.valid <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // response side stalls at random
   always @(posedge clock) begin
      rsp_ready_q <= ($urandom_range(99) >= recv_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("segment_reference_table verification failed");
         $finish;
      end
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin : monitor_b
      key_type           probe;
      table_result_type  want;
      pinned_result_type pin;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               log_mismatch($sformatf("response with nothing outstanding: status %0d index %0d",
                                      rsp_chan.status, rsp_chan.entry_index));
            end else begin
               want = expected_q.pop_front();
               if (rsp_chan.status !== want.status)
                  log_mismatch($sformatf("status expected %0d got %0d",
                                         want.status, rsp_chan.status));
               if (rsp_chan.entry_index !== want.index)
                  log_mismatch($sformatf("entry_index expected %0d got %0d",
                                         want.index, rsp_chan.entry_index));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            probe.origin_pc        = req_chan.origin_pc;
            probe.dest_pc          = req_chan.dest_pc;
            probe.link_sel         = req_chan.link_sel;
            probe.local_ref        = req_chan.local_ref;
            probe.calling_pc_flag  = req_chan.calling_pc_flag;
            probe.calling_ssn_flag = req_chan.calling_ssn_flag;
            probe.title_kind       = req_chan.title_kind;
            probe.calling_pc       = req_chan.calling_pc;
            probe.calling_ssn      = req_chan.calling_ssn;
            want = table_apply(req_chan.opcode, probe, req_chan.entry_sel);
            pin  = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
            if (pin.pinned) begin
               want.status = pin.status;
               want.index  = pin.index;
            end
            expected_q.push_back(want);
         end
      end
   end

   // stimulus
   initial begin : stimulus_b
      key_type           k;
      logic [159:0]      noise;
      logic [3:0]        sel;
      op_type            op;
      pinned_result_type pin;
      int                r;

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      drive_request(OP_LOOKUP, '0, '0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i]) begin
         pin.pinned = DIRECTED[i].pinned;
         pin.status = DIRECTED[i].status;
         pin.index  = DIRECTED[i].index;
         send_request(DIRECTED[i].op, key_pattern(int'(DIRECTED[i].pattern)),
                      DIRECTED[i].sel, pin);
      end

      // random traffic, mostly reusing keys already inserted
      pin = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct  = 61;
            recv_stall_pct = 10;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         k     = noise[$bits(key_type)-1:0];
         sel   = 4'($urandom);
         r     = $urandom_range(99);
         if (r < 25) begin
            op = OP_INSERT;
            if (key_pool.size() != 0 && $urandom_range(9) < 3) begin
               k = key_pool[$urandom_range(key_pool.size() - 1)];
            end else begin
               key_pool.push_back(k);
               if (key_pool.size() > 24)
                  key_pool.delete(0);
            end
         end else if (r < 60 && key_pool.size() != 0) begin
            // lookup of a known key, unflagged fields scrambled
            op = OP_LOOKUP;
            k  = key_pool[$urandom_range(key_pool.size() - 1)];
            if (!k.calling_pc_flag)
               k.calling_pc = 24'($urandom);
            if (!k.calling_ssn_flag)
               k.calling_ssn = 8'($urandom);
         end else if (r < 72 && key_pool.size() != 0) begin
            // near miss: one bit off in one field
            op = OP_LOOKUP;
            k  = key_pool[$urandom_range(key_pool.size() - 1)];
            case ($urandom_range(8))
               0: k.origin_pc   ^= 24'(1) << $urandom_range(23);
               1: k.dest_pc     ^= 24'(1) << $urandom_range(23);
               2: k.link_sel    ^= 8'(1) << $urandom_range(7);
               3: k.local_ref   ^= 24'(1) << $urandom_range(23);
               4: k.calling_pc_flag  = !k.calling_pc_flag;
               5: k.calling_ssn_flag = !k.calling_ssn_flag;
               6: k.title_kind  ^= 4'(1) << $urandom_range(3);
               7: k.calling_pc  ^= 24'(1) << $urandom_range(23);
               default: k.calling_ssn ^= 8'(1) << $urandom_range(7);
            endcase
         end else if (r < 76) begin
            op = OP_LOOKUP;
         end else if (r < 97) begin
            op = OP_RELEASE;
         end else begin
            op = OP_CLEAR;
         end
         send_request(op, k, sel, pin);
      end
      req_chan.valid <= 1'b0;

      // drain
      while (expected_q.size() != 0 || pinned_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
      if (fail_count == 0)
         $display("segment_reference_table verification clean");
      else
         $display("segment_reference_table verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/srt_pkg.sv
rtl/srt_req_if.sv
rtl/srt_rsp_if.sv
rtl/srt_ctrl.sv
rtl/srt_datapath.sv
rtl/segment_reference_table.sv
dv/segment_reference_table_test.sv
